// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define NFBA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nfba assertion failed");

// next-cycle implication, disabled in reset
`define NFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nfba assertion failed");

`endif

// ===== rtl/nfba_pkg.sv =====
package nfba_pkg;

    localparam int SIZE_W  = 16;
    localparam int START_W = 4;
    localparam int GRANT_W = 4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

// ===== rtl/next_fit_bitmap_allocator_top.sv =====
// an allocation sizes the request, searches the busy map with registered reads and marks the
// run before it responds; a free sizes the request, clears min(len, BLOCK_COUNT) blocks from
// the start block and responds; one request at a time
// throughput is set by the busy-map walk, one block per read or write
// reset: synchronous active-low aresetn; afterwards the busy map is swept clear,
// one block per cycle, and no request is taken meanwhile
module next_fit_bitmap_allocator_top import nfba_pkg::*; #(
    parameter int BLOCK_COUNT = 16,
    parameter int BLOCK_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // size_bytes[15:0], start_block[19:16], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // success[0], granted_block[4:1], zero pad
);

    `include "assert_macros.svh"

    localparam int IXW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int CW  = $clog2(BLOCK_COUNT + 2);
    localparam int EW  = CW + 1;
    localparam int XW  = (CW > START_W) ? CW : START_W;
    localparam int GW  = (IXW < GRANT_W) ? IXW : GRANT_W;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_SIZE  = 8'b0000_0100,
        ST_SCAN  = 8'b0000_1000,
        ST_CHECK = 8'b0001_0000,
        ST_MARK  = 8'b0010_0000,
        ST_FREE  = 8'b0100_0000,
        ST_RESP  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic               type_reg, type_next;
    logic [START_W-1:0] from_reg, from_next;
    logic [IXW-1:0]     idx_reg, idx_next;
    logic [IXW-1:0]     cand_reg, cand_next;
    logic [IXW-1:0]     search_reg, search_next;
    logic [CW-1:0]      off_reg, off_next;
    logic [CW-1:0]      run_len_reg, run_len_next;
    logic [EW-1:0]      elim_reg, elim_next;
    logic               res_ok_reg, res_ok_next;
    logic [GRANT_W-1:0] res_grant_reg, res_grant_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_data_reg, m_data_next;

    logic               map_mem [0:BLOCK_COUNT-1];
    logic               rd_bit_reg;
    logic [IXW-1:0]     rd_addr;
    logic [IXW-1:0]     wr_addr;
    logic               wr_en;
    logic               wr_bit;

    logic               len_start;
    logic               len_done;
    logic [CW-1:0]      len_val;
    logic [CW-1:0]      pos_sum;
    logic [EW-1:0]      run_end;
    logic [CW-1:0]      next_cand;

    nfba_len #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_len (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (len_start),
        .bytes   (s_tdata[SIZE_W-1:0]),
        .done    (len_done),
        .len     (len_val)
    );

    assign len_start = (state_reg == ST_IDLE) && s_tvalid;
    assign pos_sum   = CW'(cand_reg) + off_reg;
    assign run_end   = EW'(cand_reg) + EW'(run_len_reg);
    assign next_cand = pos_sum + CW'(1);
    assign rd_addr   = IXW'(pos_sum);

    always_comb begin
        state_next     = state_reg;
        type_next      = type_reg;
        from_next      = from_reg;
        idx_next       = idx_reg;
        cand_next      = cand_reg;
        search_next    = search_reg;
        off_next       = off_reg;
        run_len_next   = run_len_reg;
        elim_next      = elim_reg;
        res_ok_next    = res_ok_reg;
        res_grant_next = res_grant_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_bit         = 1'b0;
        wr_addr        = IXW'(pos_sum);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (idx_reg == IXW'(BLOCK_COUNT - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + IXW'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    type_next  = s_tuser;
                    from_next  = s_tdata[SIZE_W +: START_W];
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                if (XW'(from_reg) >= XW'(BLOCK_COUNT)) begin
                    from_next = START_W'(XW'(from_reg) - XW'(BLOCK_COUNT));
                end else if (len_done) begin
                    idx_next       = IXW'(from_reg);
                    off_next       = '0;
                    elim_next      = '0;
                    cand_next      = search_reg;
                    res_grant_next = '0;
                    run_len_next   = (len_val > CW'(BLOCK_COUNT)) ? CW'(BLOCK_COUNT) : len_val;
                    if (type_reg == REQ_FREE) begin
                        res_ok_next = 1'b1;
                        state_next  = (len_val == '0) ? ST_RESP : ST_FREE;
                    end else if ((len_val == '0) || (len_val > CW'(BLOCK_COUNT))) begin
                        res_ok_next = 1'b0;
                        state_next  = ST_RESP;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if ((off_reg == '0) && (elim_reg >= EW'(BLOCK_COUNT))) begin
                    res_ok_next = 1'b0;
                    state_next  = ST_RESP;
                end else if ((off_reg == '0) && (run_end > EW'(BLOCK_COUNT))) begin
                    // run would pass the end of the pool, skip to block zero
                    elim_next = elim_reg + (EW'(BLOCK_COUNT) - EW'(cand_reg));
                    cand_next = '0;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (rd_bit_reg) begin
                    // every start up to the busy block is ruled out
                    elim_next  = elim_reg + EW'(off_reg) + EW'(1);
                    cand_next  = (next_cand == CW'(BLOCK_COUNT)) ? '0 : IXW'(next_cand);
                    off_next   = '0;
                    state_next = ST_SCAN;
                end else if (off_reg + CW'(1) == run_len_reg) begin
                    off_next   = '0;
                    state_next = ST_MARK;
                end else begin
                    off_next   = off_reg + CW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_MARK: begin
                wr_en  = 1'b1;
                wr_bit = 1'b1;
                if (off_reg + CW'(1) == run_len_reg) begin
                    search_next    = (run_end == EW'(BLOCK_COUNT)) ? '0 : IXW'(run_end);
                    res_ok_next    = 1'b1;
                    res_grant_next = GRANT_W'(cand_reg[GW-1:0]);
                    state_next     = ST_RESP;
                end else begin
                    off_next = off_reg + CW'(1);
                end
            end
            ST_FREE: begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                idx_next = (idx_reg == IXW'(BLOCK_COUNT - 1)) ? '0 : idx_reg + IXW'(1);
                if (off_reg + CW'(1) == run_len_reg) begin
                    state_next = ST_RESP;
                end else begin
                    off_next = off_reg + CW'(1);
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, res_grant_reg, res_ok_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            search_reg  <= '0;
            cand_reg    <= '0;
            off_reg     <= '0;
            elim_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            search_reg  <= search_next;
            cand_reg    <= cand_next;
            off_reg     <= off_next;
            elim_reg    <= elim_next;
            m_valid_reg <= m_valid_next;
        end
        type_reg      <= type_next;
        from_reg      <= from_next;
        run_len_reg   <= run_len_next;
        res_ok_reg    <= res_ok_next;
        res_grant_reg <= res_grant_next;
        m_data_reg    <= m_data_next;
    end

    // busy map, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_bit;
        end
        rd_bit_reg <= map_mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `NFBA_ASSERT_IMPL(a_read_in_pool, state_reg == ST_CHECK, pos_sum < CW'(BLOCK_COUNT))
    `NFBA_ASSERT_IMPL(a_elim_bound, state_reg == ST_SCAN, elim_reg < EW'(2 * BLOCK_COUNT))
    `NFBA_ASSERT_IMPL(a_fail_grant, m_valid_reg && !m_data_reg[0], m_data_reg[4:1] == '0)
    `NFBA_ASSERT_NEXT(a_mark_done, (state_reg == ST_MARK) && (state_next == ST_RESP), res_ok_reg)

endmodule

// ===== rtl/nfba_len.sv =====
module nfba_len import nfba_pkg::*; #(
    parameter int BLOCK_COUNT = 16,
    parameter int BLOCK_BYTES = 64,
    localparam int CW = $clog2(BLOCK_COUNT + 2)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SIZE_W-1:0] bytes,
    output logic              done,
    output logic [CW-1:0]     len
);

    localparam int AW = $clog2((2 ** SIZE_W) + BLOCK_BYTES);

    logic [AW-1:0]     acc_reg, acc_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [SIZE_W-1:0] bytes_reg, bytes_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // block count by repeated add of the block size, saturating one past the pool
    always_comb begin
        acc_next   = acc_reg;
        len_next   = len_reg;
        bytes_next = bytes_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start) begin
            acc_next   = '0;
            len_next   = '0;
            bytes_next = bytes;
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end else if (busy_reg) begin
            if ((acc_reg >= AW'(bytes_reg)) || (len_reg == CW'(BLOCK_COUNT + 1))) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                acc_next = acc_reg + AW'(BLOCK_BYTES);
                len_next = len_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            acc_reg  <= '0;
            len_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            acc_reg  <= acc_next;
            len_reg  <= len_next;
        end
        bytes_reg <= bytes_next;
    end

    assign done = done_reg;
    assign len  = len_reg;

endmodule
